@@ rtl/core/apu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apu_pkg
// Shared constants and types of the admixture proportion update block.
// ----------------------------------------------------------------------------
package apu_pkg;
	localparam int CLUSTERS = 16;
	localparam int CW = $clog2(CLUSTERS);
	localparam int NW = $clog2(CLUSTERS + 1);
	localparam int IDXW = 4;
	localparam int CFG_W = 24;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [35:0] MAX36 = 36'hF_FFFF_FFFF;

	typedef enum logic [0:0] {
		CFG_STEP_WEIGHT = 1'b0,
		CFG_LOCI_COUNT  = 1'b1
	} cfg_idx_t;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_ROW  = 1'b1;

	// Row end job handed from front to back.
	typedef struct packed {
		logic [NW-1:0] count;
		logic [1:0]    geno;
		logic [35:0]   norm_a;
		logic [35:0]   norm_b;
	} row_job_t;

	typedef struct packed {
		logic [47:0] prop;
		logic [3:0]  cluster;
		logic        last;
		logic        zero;
	} res_word_t;

	typedef struct packed {
		logic        command;
		logic [3:0]  cluster_index;
		logic [15:0] allele_a_factor;
		logic [15:0] allele_b_factor;
		logic [31:0] prior_value;
		logic [1:0]  genotype;
		logic [47:0] old_proportion;
		logic [15:0] row_weight;
		logic        row_last;
	} in_word_t;
endpackage
`default_nettype wire

@@ rtl/core/apu_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apu_in_if / apu_out_if
// Valid/ready channels for input and result words.
// ----------------------------------------------------------------------------
interface apu_in_if import apu_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface apu_out_if import apu_pkg::*; ();
	logic      valid;
	logic      ready;
	res_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/apu_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apu_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module apu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/apu_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apu_div
// Restoring divider, one quotient bit a cycle: (num << 32) / den, 49 bits.
// ----------------------------------------------------------------------------
module apu_div import apu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] num,
	input  wire logic [35:0] den,
	output logic             done,
	output logic [48:0]      quot
);
	logic [47:0] rem_q;
	logic [47:0] dividend_q;
	logic [35:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [48:0] trial;

	assign trial = {rem_q, dividend_q[47]} - {13'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q     <= 1'b1;
				cnt_q      <= 6'd48;
				rem_q      <= '0;
				dividend_q <= {num, 32'd0};
				den_q      <= den;
				quot       <= '0;
			end else if (busy_q) begin
				// One quotient bit per cycle; numerator is 48 bits wide.
				if (!trial[48]) begin
					rem_q <= trial[47:0];
					quot  <= {quot[47:0], 1'b1};
				end else begin
					rem_q <= {rem_q[46:0], dividend_q[47]};
					quot  <= {quot[47:0], 1'b0};
				end
				dividend_q <= {dividend_q[46:0], 1'b0};
				cnt_q      <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/apu_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apu_front
// Accept words, write tables and row buffers, accumulate norms, post jobs.
// ----------------------------------------------------------------------------
module apu_front import apu_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	apu_in_if.sink             in_ch,
	input  wire logic          hold,
	output logic               tab_we,
	output logic               buf_we,
	output logic [CW-1:0]      waddr,
	output logic               job_valid,
	output row_job_t           job
);
	logic [35:0]   norm_a_q, norm_b_q;
	logic [NW-1:0] len_q;
	logic [15:0]   a_tab_q [CLUSTERS];
	logic [15:0]   b_tab_q [CLUSTERS];
	logic          acc;
	logic          in_range;
	logic [CW-1:0] k;
	logic [36:0]   sum_a, sum_b;
	logic [35:0]   na_n, nb_n;

	assign in_ch.ready = !hold;
	assign acc = in_ch.valid && in_ch.ready;
	assign in_range = {{(32-IDXW){1'b0}}, in_ch.data.cluster_index} < CLUSTERS;
	assign k = CW'(in_ch.data.cluster_index);
	assign waddr = k;
	assign tab_we = acc && in_ch.data.command == CMD_LOAD && in_range;
	assign buf_we = acc && in_ch.data.command == CMD_ROW && in_range;

	assign sum_a = {1'b0, norm_a_q} + 37'(a_tab_q[k] * in_ch.data.row_weight);
	assign sum_b = {1'b0, norm_b_q} + 37'(b_tab_q[k] * in_ch.data.row_weight);
	assign na_n = in_range ? (sum_a[36] ? MAX36 : sum_a[35:0]) : norm_a_q;
	assign nb_n = in_range ? (sum_b[36] ? MAX36 : sum_b[35:0]) : norm_b_q;

	always_ff @(posedge clk) begin
		if (tab_we) begin
			a_tab_q[k] <= in_ch.data.allele_a_factor;
			b_tab_q[k] <= in_ch.data.allele_b_factor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_a_q  <= '0;
			norm_b_q  <= '0;
			len_q     <= '0;
			job_valid <= 1'b0;
			job       <= '0;
		end else begin
			job_valid <= 1'b0;
			if (acc && in_ch.data.command == CMD_ROW) begin
				if (in_ch.data.row_last) begin
					job_valid   <= 1'b1;
					job.count   <= (len_q < NW'(CLUSTERS)) ? len_q + NW'(1) : len_q;
					job.geno    <= in_ch.data.genotype;
					job.norm_a  <= na_n;
					job.norm_b  <= nb_n;
					norm_a_q    <= '0;
					norm_b_q    <= '0;
					len_q       <= '0;
				end else begin
					norm_a_q <= na_n;
					norm_b_q <= nb_n;
					if (len_q < NW'(CLUSTERS)) begin
						len_q <= len_q + NW'(1);
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/apu_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apu_back
// Sequence one row job: per cluster, two divides, scale, add prior, blend, emit.
// ----------------------------------------------------------------------------
module apu_back import apu_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	input  row_job_t           job,
	output logic               busy,
	input  wire logic [16:0]   step_weight,
	input  wire logic [23:0]   loci_count,
	output logic [CW-1:0]      raddr,
	input  wire logic [15:0]   a_rd,
	input  wire logic [15:0]   b_rd,
	input  wire logic [31:0]   p_rd,
	input  wire logic [15:0]   w_rd,
	input  wire logic [47:0]   o_rd,
	apu_out_if.source          out_ch
);
	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_DIVA, S_WAITA, S_DIVB, S_WAITB, S_SUM, S_WMUL,
		S_JMUL, S_PRIOR, S_BLEND, S_OUT
	} state_t;

	state_t        state_q;
	row_job_t      job_q;
	logic [CW-1:0] idx_q;
	logic [15:0]   b_q, w_q;
	logic [31:0]   p_q;
	logic [47:0]   o_q;
	logic [50:0]   t_q;
	logic [66:0]   tw_q;
	logic [55:0]   jlo_q;
	logic [47:0]   lik_q, inner_q;
	logic          div_start;
	logic [15:0]   div_num;
	logic [35:0]   div_den;
	logic          div_done;
	logic [48:0]   quot;
	logic [1:0]    g;
	logic [16:0]   rho;
	logic [48:0]   padd;
	logic [90:0]   jprod;
	logic [65:0]   bl_hi, bl_lo;
	logic [65:0]   bl;

	assign g = (job_q.geno == 2'd3) ? 2'd2 : job_q.geno;
	assign rho = (step_weight > 17'd65536) ? 17'd65536 : step_weight;
	assign raddr = idx_q;
	assign busy = state_q != S_IDLE;
	assign div_start = state_q == S_DIVA || state_q == S_DIVB;
	// The a factor is read straight off the RAM while the first divide starts.
	assign div_num = (state_q == S_DIVA) ? a_rd : b_q;
	assign div_den = (state_q == S_DIVA) ? job_q.norm_a : job_q.norm_b;

	apu_div u_div (
		.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quot
	);

	// Scale by J in two halves: low 32 bits first, then the upper part.
	assign jprod = {59'(tw_q[66:32] * loci_count), 32'd0} + 91'(jlo_q);
	assign padd = {17'd0, p_q} + {1'b0, lik_q};
	assign bl_hi = 66'(17'(17'd65536 - rho) * o_q[47:16]) + 66'(rho * inner_q[47:16]);
	assign bl_lo = 66'(17'(17'd65536 - rho) * o_q[15:0]) + 66'(rho * inner_q[15:0]);
	assign bl = bl_hi + (bl_lo >> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_ch.valid <= 1'b0;
			idx_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						job_q   <= job;
						idx_q   <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_DIVA;
				end
				S_DIVA: begin
					b_q     <= b_rd;
					p_q     <= p_rd;
					w_q     <= w_rd;
					o_q     <= o_rd;
					t_q     <= '0;
					state_q <= S_WAITA;
				end
				S_WAITA: begin
					if (div_done) begin
						if (job_q.norm_a != '0) begin
							t_q <= 51'(quot * g);
						end
						state_q <= S_DIVB;
					end
				end
				S_DIVB: begin
					state_q <= S_WAITB;
				end
				S_WAITB: begin
					if (div_done) begin
						if (job_q.norm_b != '0) begin
							t_q <= t_q + 51'(quot * 2'(2'd2 - g));
						end
						state_q <= S_WMUL;
					end
				end
				S_WMUL: begin
					tw_q    <= 67'(t_q[50:16] * w_q) + 67'((t_q[15:0] * w_q) >> 16);
					state_q <= S_JMUL;
				end
				S_JMUL: begin
					jlo_q   <= 56'(tw_q[31:0] * loci_count);
					state_q <= S_SUM;
				end
				S_SUM: begin
					lik_q   <= (jprod > 91'(MAX48)) ? MAX48 : jprod[47:0];
					state_q <= S_PRIOR;
				end
				S_PRIOR: begin
					inner_q <= padd[48] ? MAX48 : padd[47:0];
					state_q <= S_BLEND;
				end
				S_BLEND: begin
					out_ch.data.prop    <= bl[47:0];
					out_ch.data.cluster <= 4'(idx_q);
					out_ch.data.last    <= NW'(idx_q) + NW'(1) == job_q.count;
					out_ch.data.zero    <= job_q.norm_a == '0 || job_q.norm_b == '0;
					out_ch.valid        <= 1'b1;
					state_q             <= S_OUT;
				end
				S_OUT: begin
					if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						if (out_ch.data.last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_READ;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ap_valid_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> state_q == S_OUT) else $error("valid outside output state");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_ch.data))
		else $error("result changed while stalled");
	ap_idx: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> NW'(idx_q) < job_q.count) else $error("index past row length");
endmodule
`default_nettype wire

@@ rtl/core/admixture_proportion_update.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// admixture_proportion_update
// Blend new cluster proportions from buffered row words and loaded tables.
// ----------------------------------------------------------------------------
// Usage: in_ch carries words. A command 0 word loads the factor and prior
// tables of one cluster; command 1 words form a row, one per cluster, the
// last one flagged by row_last. The front accepts one word a cycle unless
// held, writes the row buffers and accumulates both weighted norms. On the
// last word it posts a job (one deep queue) to the back, which emits one
// result word per buffered cluster on out_ch.
// Per cluster the back reads the tables, runs two serial divisions, then
// scales, adds the prior, blends and emits; an output stall holds it.
// While a job is pending or running the front stalls (ready low), so a
// new row waits for the previous results.
// Reset clears norms, row length, the job queue and config (rho = 1, J = 1);
// tables and buffers hold garbage until written.
// A stalled receiver holds the back in its output state; results wait.
// cfg_we/cfg_index/cfg_data write step_weight (0) and loci_count (1).
// ----------------------------------------------------------------------------
module admixture_proportion_update import apu_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	apu_in_if.sink                in_ch,
	apu_out_if.source             out_ch
);
	logic [16:0]   step_weight_q;
	logic [23:0]   loci_count_q;
	logic          tab_we, buf_we;
	logic [CW-1:0] waddr, raddr;
	logic          job_valid, back_busy;
	row_job_t      job;
	logic          hold;
	logic [15:0]   a_rd, b_rd, w_rd;
	logic [31:0]   p_rd;
	logic [47:0]   o_rd;

	// Hold input while a row job is in flight.
	assign hold = back_busy || job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_weight_q <= 17'd65536;
			loci_count_q  <= 24'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEP_WEIGHT: step_weight_q <= cfg_data[16:0];
				CFG_LOCI_COUNT:  loci_count_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	apu_front u_front (
		.clk, .arst_n, .in_ch, .hold, .tab_we, .buf_we, .waddr, .job_valid, .job
	);

	apu_ram #(.WIDTH(16), .DEPTH(CLUSTERS)) u_a (.clk, .we(tab_we), .waddr,
		.wdata(in_ch.data.allele_a_factor), .raddr, .rdata(a_rd));
	apu_ram #(.WIDTH(16), .DEPTH(CLUSTERS)) u_b (.clk, .we(tab_we), .waddr,
		.wdata(in_ch.data.allele_b_factor), .raddr, .rdata(b_rd));
	apu_ram #(.WIDTH(32), .DEPTH(CLUSTERS)) u_p (.clk, .we(tab_we), .waddr,
		.wdata(in_ch.data.prior_value), .raddr, .rdata(p_rd));
	apu_ram #(.WIDTH(16), .DEPTH(CLUSTERS)) u_w (.clk, .we(buf_we), .waddr,
		.wdata(in_ch.data.row_weight), .raddr, .rdata(w_rd));
	apu_ram #(.WIDTH(48), .DEPTH(CLUSTERS)) u_o (.clk, .we(buf_we), .waddr,
		.wdata(in_ch.data.old_proportion), .raddr, .rdata(o_rd));

	apu_back u_back (
		.clk, .arst_n, .job_valid, .job, .busy(back_busy),
		.step_weight(step_weight_q), .loci_count(loci_count_q), .raddr,
		.a_rd, .b_rd, .p_rd, .w_rd, .o_rd, .out_ch
	);

	ap_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		back_busy |-> !in_ch.ready) else $error("input taken during row job");
	ap_job_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> !back_busy) else $error("job posted while back busy");
	ap_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> back_busy) else $error("result without job");
endmodule
`default_nettype wire
